// ===== hw/rtl/ccs_pkg.sv =====
package ccs_pkg;

  // Context ID width and bitmap size
  localparam int ID_W         = 6;
  localparam int MAP_W        = 2 ** ID_W;
  // IDs at or above this limit are never live
  localparam int MAX_CONTEXTS = 64;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SCHED  = 3'd2,
    OP_YIELD  = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/cooperative_context_scheduler.sv =====
// Flow: a request applies its bitmap update, ST_SCAN walks all 64 IDs bit-serially,
// then ST_DONE waits for the output slot and registers the result. One request at a
// time; the next request is taken while the last result is still held.
// Reset: rst_n synchronous, active low; clears the live bitmap, the current context
// and all handshake state.
module cooperative_context_scheduler (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_op,
  input  logic [ccs_pkg::ID_W-1:0]  in_context_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ccs_pkg::ID_W-1:0]  out_current_id,
  output logic                      out_has_current,
  output logic                      out_set_empty,
  output logic                      out_reschedule,
  output logic                      out_error
);
  import ccs_pkg::*;

  state_t            state_r, state_nxt;
  logic [MAP_W-1:0]  map_r, map_nxt;
  logic [ID_W-1:0]   cur_r, cur_nxt;
  logic              ok_r, ok_nxt;
  op_t               op_r, op_nxt;
  logic              resched_r, resched_nxt;
  logic              err_r, err_nxt;
  logic [ID_W-1:0]   idx_r, idx_nxt;
  logic [ID_W-1:0]   hi_all_r, hi_all_nxt;
  logic [ID_W-1:0]   hi_below_r, hi_below_nxt;
  logic              below_found_r, below_found_nxt;
  logic [ID_W-1:0]   lo_r, lo_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_hc_r, out_hc_nxt;
  logic              out_se_r, out_se_nxt;
  logic              out_rs_r, out_rs_nxt;
  logic              out_er_r, out_er_nxt;
  logic              out_load;

  logic              accept;
  logic              id_valid;
  logic              scan_bit;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign id_valid  = (32'(in_context_id) < MAX_CONTEXTS);
  assign scan_bit  = map_r[idx_r];
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt       = state_r;
    map_nxt         = map_r;
    cur_nxt         = cur_r;
    ok_nxt          = ok_r;
    op_nxt          = op_r;
    resched_nxt     = resched_r;
    err_nxt         = err_r;
    idx_nxt         = idx_r;
    hi_all_nxt      = hi_all_r;
    hi_below_nxt    = hi_below_r;
    below_found_nxt = below_found_r;
    lo_nxt          = lo_r;
    cnt_nxt         = cnt_r;
    out_id_nxt      = out_id_r;
    out_hc_nxt      = out_hc_r;
    out_se_nxt      = out_se_r;
    out_rs_nxt      = out_rs_r;
    out_er_nxt      = out_er_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    case (state_r)
      // Apply the bitmap part of the request, then start the scan
      ST_IDLE: begin
        if (accept) begin
          op_nxt          = op_t'(in_op);
          resched_nxt     = 1'b0;
          err_nxt         = 1'b0;
          idx_nxt         = ID_W'(MAP_W - 1);
          cnt_nxt         = 2'd0;
          below_found_nxt = 1'b0;
          state_nxt       = ST_SCAN;
          case (op_t'(in_op))
            OP_ADD: begin
              if (id_valid) map_nxt[in_context_id] = 1'b1;
            end
            OP_REMOVE: begin
              if (id_valid) begin
                map_nxt[in_context_id] = 1'b0;
                if (ok_r && cur_r == in_context_id) ok_nxt = 1'b0;
              end
            end
            OP_SCHED: begin
              if (id_valid && map_r[in_context_id]) begin
                cur_nxt     = in_context_id;
                ok_nxt      = 1'b1;
                resched_nxt = 1'b1;
              end else begin
                err_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      // One bit per cycle, from the top ID down
      ST_SCAN: begin
        if (scan_bit) begin
          if (cnt_r == 2'd0) hi_all_nxt = idx_r;
          if (idx_r < cur_r && !below_found_r) begin
            hi_below_nxt    = idx_r;
            below_found_nxt = 1'b1;
          end
          lo_nxt = idx_r;
          if (cnt_r != 2'd2) cnt_nxt = cnt_r + 2'd1;
        end
        if (idx_r == '0) state_nxt = ST_DONE;
        else             idx_nxt   = idx_r - ID_W'(1);
      end

      // Yield, query check and lowest-ID pick; wait for the output slot
      ST_DONE: begin
        if (out_load) begin
          if (op_r == OP_YIELD && ok_r && cnt_r == 2'd2) begin
            cur_nxt     = below_found_r ? hi_below_r : hi_all_r;
            resched_nxt = 1'b1;
          end
          if (op_r == OP_QUERY && cnt_r == 2'd0) err_nxt = 1'b1;
          if (!ok_r && cnt_r != 2'd0) begin
            cur_nxt = lo_r;
            ok_nxt  = 1'b1;
          end
          out_id_nxt    = ok_nxt ? cur_nxt : '0;
          out_hc_nxt    = ok_nxt;
          out_se_nxt    = (cnt_r == 2'd0);
          out_rs_nxt    = resched_nxt;
          out_er_nxt    = err_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      map_r       <= '0;
      cur_r       <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_r       <= map_nxt;
      cur_r       <= cur_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    resched_r     <= resched_nxt;
    err_r         <= err_nxt;
    idx_r         <= idx_nxt;
    hi_all_r      <= hi_all_nxt;
    hi_below_r    <= hi_below_nxt;
    below_found_r <= below_found_nxt;
    lo_r          <= lo_nxt;
    cnt_r         <= cnt_nxt;
    out_id_r      <= out_id_nxt;
    out_hc_r      <= out_hc_nxt;
    out_se_r      <= out_se_nxt;
    out_rs_r      <= out_rs_nxt;
    out_er_r      <= out_er_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_current_id  = out_id_r;
  assign out_has_current = out_hc_r;
  assign out_set_empty   = out_se_r;
  assign out_reschedule  = out_rs_r;
  assign out_error       = out_er_r;

endmodule

// ===== hw/rtl/ccs_checker.sv =====
module ccs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ccs_pkg::ID_W-1:0]  out_current_id,
  input logic                      out_has_current,
  input logic                      out_set_empty,
  input logic                      out_reschedule,
  input logic                      out_error
);
  import ccs_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_current_id) &&
      $stable(out_has_current) && $stable(out_set_empty) &&
      $stable(out_reschedule) && $stable(out_error))
    else $error("result changed while stalled");

  // Busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after accept");

  // A current context exists exactly when the set is not empty
  a_current_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_has_current != out_set_empty))
    else $error("current flag disagrees with set status");

  // No current context reports ID zero
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_current |-> out_current_id == '0)
    else $error("nonzero ID without current context");

  // A switch and an error never come together
  a_rs_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_reschedule && out_error))
    else $error("reschedule and error both set");

endmodule

bind cooperative_context_scheduler ccs_checker u_ccs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_current_id  (out_current_id),
  .out_has_current (out_has_current),
  .out_set_empty   (out_set_empty),
  .out_reschedule  (out_reschedule),
  .out_error       (out_error)
);

// ===== tb/tb_cooperative_context_scheduler.sv =====
module tb_cooperative_context_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import ccs_pkg::*;

  // Opcodes the block has no use for; they must leave the state alone
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  localparam int ID_TOP          = MAP_W - 1;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 700;
  // idle slack at the end, after the last result has drained
  localparam int TAIL_CYCLES     = 80;

  typedef struct packed {
    logic [ID_W-1:0] current_id;
    logic            has_current;
    logic            set_empty;
    logic            reschedule;
    logic            error;
  } sched_status_t;

  typedef enum int {SINK_OPEN, SINK_FLICKER, SINK_BLOCKED} sink_mode_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [2:0]      in_op;
  logic [ID_W-1:0] in_context_id;
  logic            out_valid;
  logic            out_ready;
  logic [ID_W-1:0] out_current_id;
  logic            out_has_current;
  logic            out_set_empty;
  logic            out_reschedule;
  logic            out_error;

  // Scheduler state as the testbench sees it
  logic [MAP_W-1:0] pred_live;
  logic [ID_W-1:0]  pred_cur;
  logic             pred_cur_ok;

  sched_status_t status_q[$];
  sched_status_t seen_status;

  int  fail_count;
  int  results_checked;
  int  cycle_count;
  int  error_flags;
  int  reschedules;
  int  op_count [8];
  bit  hold_off_req;

  cooperative_context_scheduler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_context_id   (in_context_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_current_id  (out_current_id),
    .out_has_current (out_has_current),
    .out_set_empty   (out_set_empty),
    .out_reschedule  (out_reschedule),
    .out_error       (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cooperative_context_scheduler regression: fail");
      $finish;
    end
  end

  // Highest live ID in a bitmap
  function automatic logic [ID_W-1:0] top_live(input logic [MAP_W-1:0] map);
    logic [ID_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAP_W; i++)
      if (map[i]) idx = ID_W'(i);
    return idx;
  endfunction

  // Apply one request to the tracked state and return the status it reports
  function automatic sched_status_t predict_step(input logic [2:0] op,
                                                 input logic [ID_W-1:0] id);
    sched_status_t    st;
    logic [MAP_W-1:0] id_bit;
    logic [MAP_W-1:0] cur_bit;
    logic [MAP_W-1:0] below;
    st = '0;
    id_bit = '0;
    if (id < MAX_CONTEXTS) id_bit[id] = 1'b1;
    cur_bit = '0;
    cur_bit[pred_cur] = 1'b1;
    case (op)
      OP_ADD: pred_live |= id_bit;
      OP_REMOVE: begin
        pred_live &= ~id_bit;
        if (id_bit != '0 && pred_cur_ok && pred_cur == id) pred_cur_ok = 1'b0;
      end
      OP_SCHED: begin
        if ((pred_live & id_bit) != '0) begin
          pred_cur = id;
          pred_cur_ok = 1'b1;
          st.reschedule = 1'b1;
        end else begin
          st.error = 1'b1;
        end
      end
      OP_YIELD: begin
        // step to the next lower live ID, wrapping to the highest
        if (pred_cur_ok && $countones(pred_live) > 1) begin
          below = pred_live & (cur_bit - 1'b1);
          pred_cur = (below != '0) ? top_live(below) : top_live(pred_live);
          st.reschedule = 1'b1;
        end
      end
      OP_QUERY: if (pred_live == '0) st.error = 1'b1;
      default: ;
    endcase
    // lowest live ID takes over when nothing is current
    if (!pred_cur_ok && pred_live != '0) begin
      for (int i = MAP_W - 1; i >= 0; i--)
        if (pred_live[i]) pred_cur = ID_W'(i);
      pred_cur_ok = 1'b1;
    end
    st.current_id  = pred_cur_ok ? pred_cur : '0;
    st.has_current = pred_cur_ok;
    st.set_empty   = (pred_live == '0);
    return st;
  endfunction

  // Send one request; valid stays up unless a gap follows
  task automatic send_request(input logic [2:0] op, input logic [ID_W-1:0] id,
                              input int gap);
    sched_status_t st;
    in_valid      <= 1'b1;
    in_op         <= op;
    in_context_id <= id;
    do @(posedge clk); while (!in_ready);
    st = predict_step(op, id);
    status_q.push_back(st);
    op_count[op]++;
    error_flags += st.error;
    reschedules += st.reschedule;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (status_q.size() != 0) @(posedge clk);
  endtask

  // Pick an ID, from the live set when asked and possible
  function automatic logic [ID_W-1:0] pick_id(input bit want_live);
    logic [ID_W-1:0] id;
    if (want_live && pred_live != '0) begin
      do id = ID_W'($urandom_range(0, ID_TOP)); while (!pred_live[id]);
    end else if ($urandom_range(0, 1) != 0) begin
      // crowd the two ends of the ID range
      id = ID_W'($urandom_range(0, 7) + ($urandom_range(0, 1) != 0 ? MAP_W - 8 : 0));
    end else begin
      id = ID_W'($urandom_range(0, ID_TOP));
    end
    return id;
  endfunction

  // Weighted request mix; adds favored while the set is nearly empty
  task automatic pick_request(output logic [2:0] op, output logic [ID_W-1:0] id);
    int r;
    r = $urandom_range(0, 99);
    if ($countones(pred_live) < 3 && r >= 50) r = $urandom_range(0, 29);
    if (r < 30) begin
      op = OP_ADD;
      id = pick_id(1'b0);
    end else if (r < 50) begin
      op = OP_REMOVE;
      id = pick_id($urandom_range(0, 2) != 0);
    end else if (r < 68) begin
      op = OP_SCHED;
      id = pick_id($urandom_range(0, 3) != 0);
    end else if (r < 88) begin
      op = OP_YIELD;
      id = ID_W'($urandom_range(0, ID_TOP));
    end else if (r < 96) begin
      op = OP_QUERY;
      id = ID_W'($urandom_range(0, ID_TOP));
    end else begin
      op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      id = ID_W'($urandom_range(0, ID_TOP));
    end
  endtask

  // Result check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $error("result with no request outstanding: current_id %0d", out_current_id);
        fail_count++;
      end else begin
        seen_status = status_q.pop_front();
        results_checked++;
        if (out_current_id !== seen_status.current_id) begin
          $error("current_id: expected %0d, got %0d", seen_status.current_id,
                 out_current_id);
          fail_count++;
        end
        if (out_has_current !== seen_status.has_current) begin
          $error("has_current: expected %0d, got %0d", seen_status.has_current,
                 out_has_current);
          fail_count++;
        end
        if (out_set_empty !== seen_status.set_empty) begin
          $error("set_empty: expected %0d, got %0d", seen_status.set_empty,
                 out_set_empty);
          fail_count++;
        end
        if (out_reschedule !== seen_status.reschedule) begin
          $error("reschedule: expected %0d, got %0d", seen_status.reschedule,
                 out_reschedule);
          fail_count++;
        end
        if (out_error !== seen_status.error) begin
          $error("error: expected %0d, got %0d", seen_status.error, out_error);
          fail_count++;
        end
      end
    end
  end

  // Result sink: open, flickering or blocked stretches, plus a long hold-off on demand
  initial begin : result_sink
    int         run_left;
    sink_mode_t sink_mode;
    run_left  = 0;
    sink_mode = SINK_OPEN;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_off_req = 1'b0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          sink_mode = sink_mode_t'($urandom_range(0, 2));
          run_left = (sink_mode == SINK_BLOCKED) ? $urandom_range(1, 90)
                                                 : $urandom_range(50, 400);
        end
        run_left--;
        case (sink_mode)
          SINK_OPEN:    out_ready <= 1'b1;
          SINK_FLICKER: out_ready <= ($urandom_range(0, 3) != 0);
          default:      out_ready <= 1'b0;
        endcase
      end
    end
  end

  // Corner cases: empty set, both ID extremes, wrap-around, spare opcodes
  task automatic test_directed();
    send_request(OP_QUERY,     6'd0,  0);  // query with nothing live
    send_request(OP_YIELD,     6'd0,  1);  // yield with nothing live
    send_request(OP_SCHED,     6'd21, 0);  // schedule absent ID on empty set
    send_request(OP_REMOVE,    6'd42, 2);  // remove absent ID
    send_request(OP_SPARE_LO,  6'd63, 0);
    send_request(OP_ADD,       6'd63, 0);  // first add becomes current
    send_request(OP_ADD,       6'd0,  3);
    send_request(OP_ADD,       6'd63, 0);  // add an already live ID
    send_request(OP_YIELD,     6'd0,  0);  // 63 -> 0
    send_request(OP_YIELD,     6'd0,  1);  // wrap 0 -> 63
    send_request(OP_SCHED,     6'd0,  0);
    send_request(OP_SCHED,     6'd0,  0);  // schedule the current ID again
    send_request(OP_SCHED,     6'd42, 5);  // absent ID keeps current
    send_request(OP_QUERY,     6'd63, 0);
    send_request(OP_ADD,       6'd21, 0);
    send_request(OP_YIELD,     6'd0,  0);  // wrap 0 -> 63
    send_request(OP_YIELD,     6'd0,  0);  // 63 -> 21
    send_request(OP_REMOVE,    6'd21, 2);  // drop current, lowest takes over
    send_request(OP_REMOVE,    6'd0,  0);
    send_request(OP_YIELD,     6'd0,  0);  // single live context
    send_request(OP_SPARE_MID, 6'd42, 0);
    send_request(OP_REMOVE,    6'd63, 0);  // set goes empty
    send_request(OP_SPARE_HI,  6'd0,  0);
    send_request(OP_QUERY,     6'd0,  1);
  endtask

  // Random mix, sent in bursts with random gaps
  task automatic test_random(input int count);
    logic [2:0]      op;
    logic [ID_W-1:0] id;
    int              burst_left;
    int              gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) burst_left = $urandom_range(1, 12);
      burst_left--;
      gap = (burst_left == 0 && $urandom_range(0, 3) != 0) ? $urandom_range(1, 90) : 0;
      if (i == count - 1 && gap == 0) gap = 1;
      pick_request(op, id);
      send_request(op, id, gap);
    end
  endtask

  // Sink holds off while requests keep coming, so the block fills and stalls
  task automatic test_backpressure();
    logic [2:0]      op;
    logic [ID_W-1:0] id;
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      pick_request(op, id);
      send_request(op, id, (i == 11) ? 1 : 0);
    end
    wait_drained();
  endtask

  // Source pauses halfway until every result sent so far has drained
  task automatic test_drain_pause();
    logic [2:0]      op;
    logic [ID_W-1:0] id;
    for (int i = 0; i < 16; i++) begin
      pick_request(op, id);
      send_request(op, id, (i == 7 || i == 15) ? 1 : 0);
      if (i == 7) wait_drained();
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= '0;
    in_context_id <= '0;
    hold_off_req  = 1'b0;
    pred_live     = '0;
    pred_cur      = '0;
    pred_cur_ok   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200);
    test_backpressure();
    test_drain_pause();
    test_random(250);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d add, %0d remove, %0d schedule, %0d yield, %0d query, %0d spare",
             op_count[OP_ADD], op_count[OP_REMOVE], op_count[OP_SCHED],
             op_count[OP_YIELD], op_count[OP_QUERY],
             op_count[OP_SPARE_LO] + op_count[OP_SPARE_MID] + op_count[OP_SPARE_HI]);
    $display("%0d results checked, %0d error flags, %0d reschedules, %0d mismatches",
             results_checked, error_flags, reschedules, fail_count);
    if (fail_count == 0 && status_q.size() == 0) begin
      $display("cooperative_context_scheduler regression: pass");
    end else begin
      $display("cooperative_context_scheduler regression: fail");
    end
    $finish;
  end

endmodule
